>>> sv/dpc_pkg.sv
// Shared types and constants for the depth image back-projection block.
// Used by the front end, the item queue, the projection pipeline and the top level.
// No dependencies.
package dpc_pkg;

    // Frame geometry limits and field widths
    localparam int MaxCols    = 1024;
    localparam int MaxRows    = 1024;
    localparam int DepthBits  = 16;
    localparam int ColBits    = 10;
    localparam int RowBits    = 10;
    localparam int DimBits    = 11;
    localparam int CenterBits = 14;
    localparam int InvBits    = 24;
    localparam int CoordBits  = 23;
    localparam int ZBits      = 16;
    localparam int ColourBits = 8;

    // Configuration port
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 24;

    // Register indexes of the configuration port
    localparam logic [CfgIndexBits-1:0] RegColsInUse  = 3'd0;
    localparam logic [CfgIndexBits-1:0] RegRowsInUse  = 3'd1;
    localparam logic [CfgIndexBits-1:0] RegCenterXQ4  = 3'd2;
    localparam logic [CfgIndexBits-1:0] RegCenterYQ4  = 3'd3;
    localparam logic [CfgIndexBits-1:0] RegInvFocalX  = 3'd4;
    localparam logic [CfgIndexBits-1:0] RegInvFocalY  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [DimBits-1:0]    ColsReset    = 11'd640;
    localparam logic [DimBits-1:0]    RowsReset    = 11'd480;
    localparam logic [CenterBits-1:0] CenterXReset = 14'd4976;
    localparam logic [CenterBits-1:0] CenterYReset = 14'd3904;
    localparam logic [InvBits-1:0]    InvFxReset   = 24'd28292;
    localparam logic [InvBits-1:0]    InvFyReset   = 24'd28532;

    // Stream widths
    localparam int InDataBits  = 40;
    localparam int OutDataBits = 88;

    // Queue depth between front and back
    localparam int QueueDepth    = 4;
    localparam int QueuePtrBits  = 2;
    localparam int QueueCntBits  = 3;

    // One classified pixel handed from the front end to the projection pipeline
    typedef struct packed {
        logic [DepthBits-1:0]  depth;
        logic                  has_color;
        logic [ColourBits-1:0] blue;
        logic [ColourBits-1:0] green;
        logic [ColourBits-1:0] red;
        logic [ColBits-1:0]    col;
        logic [RowBits-1:0]    row;
        logic                  point_valid;
        logic                  frame_end;
    } dpc_item_t;

    // Camera settings seen by the projection pipeline
    typedef struct packed {
        logic [CenterBits-1:0] center_x_q4;
        logic [CenterBits-1:0] center_y_q4;
        logic [InvBits-1:0]    inv_focal_x;
        logic [InvBits-1:0]    inv_focal_y;
    } dpc_cam_t;

endpackage

>>> sv/depth_to_point_cloud.sv
// Top level of the depth image back-projection block: configuration registers and
// the front end, queue and projection pipeline. Depends on dpc_pkg and the dpc_ modules.
//
// Depth pixels enter in raster order and one item per cycle is sustained while
// m_tready stays high. Each item with a nonzero depth leaves as a 3D point (x, y
// with 4 fraction bits, z equal to depth); the last pixel of a frame always yields
// an item with tlast set. Each point passes the queue write, the three pipeline
// stages and the output register; a four-entry queue lets the input side run on
// while the output is stalled. Camera settings must be written through the cfg_
// port only while no item is in flight; the block itself does not enforce this.
module depth_to_point_cloud
    import dpc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Pixel input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [InDataBits-1:0]   s_tdata,   // depth_sample, blue_in, green_in, red_in
    input  logic                    s_tuser,   // has_color
    // Point output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataBits-1:0]  m_tdata,   // point_x, point_y, point_z, blue_out,
                                               // green_out, red_out, zero padding
    output logic [1:0]              m_tuser,   // color_present, point_valid
    output logic                    m_tlast,   // frame_end
    // Configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgDataBits-1:0]  cfg_data
);

    logic [DimBits-1:0]    cols_reg, rows_reg;
    logic [CenterBits-1:0] cx_reg, cy_reg;
    logic [InvBits-1:0]    ifx_reg, ify_reg;
    dpc_cam_t              cam;
    logic                  push, q_full, q_pop, q_not_empty;
    dpc_item_t             push_item, head_item;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= ColsReset;
            rows_reg <= RowsReset;
            cx_reg   <= CenterXReset;
            cy_reg   <= CenterYReset;
            ifx_reg  <= InvFxReset;
            ify_reg  <= InvFyReset;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                RegColsInUse: cols_reg <= cfg_data[DimBits-1:0];
                RegRowsInUse: rows_reg <= cfg_data[DimBits-1:0];
                RegCenterXQ4: cx_reg   <= cfg_data[CenterBits-1:0];
                RegCenterYQ4: cy_reg   <= cfg_data[CenterBits-1:0];
                RegInvFocalX: ifx_reg  <= cfg_data[InvBits-1:0];
                RegInvFocalY: ify_reg  <= cfg_data[InvBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cam.center_x_q4 = cx_reg;
        cam.center_y_q4 = cy_reg;
        cam.inv_focal_x = ifx_reg;
        cam.inv_focal_y = ify_reg;
    end

    dpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cols_in_use (cols_reg),
        .rows_in_use (rows_reg),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    dpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    dpc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cam         (cam),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> sv/dpc_front.sv
// Front end: accepts depth pixels, tracks column and row, and classifies each item.
// Depends on dpc_pkg.
module dpc_front
    import dpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [InDataBits-1:0]  s_tdata,   // depth_sample, blue_in, green_in, red_in
    input  logic                   s_tuser,   // has_color
    input  logic [DimBits-1:0]     cols_in_use,
    input  logic [DimBits-1:0]     rows_in_use,
    input  logic                   q_full,
    output logic                   push,
    output dpc_item_t              push_item
);

    logic [ColBits-1:0] col_reg, col_next;
    logic [RowBits-1:0] row_reg, row_next;
    logic [DimBits-1:0] cols_cl, rows_cl;
    logic [DimBits-1:0] col_inc, row_inc;
    logic               row_end, last, accept, depth_nz;
    logic [DepthBits-1:0] depth;

    // Clamp the frame geometry into its legal range
    always_comb begin
        cols_cl = cols_in_use;
        if (cols_in_use == '0) begin
            cols_cl = DimBits'(1);
        end else if (cols_in_use > DimBits'(MaxCols)) begin
            cols_cl = DimBits'(MaxCols);
        end
        rows_cl = rows_in_use;
        if (rows_in_use == '0) begin
            rows_cl = DimBits'(1);
        end else if (rows_in_use > DimBits'(MaxRows)) begin
            rows_cl = DimBits'(MaxRows);
        end
    end

    // Position classification; a counter at or past the end counts as the end
    assign col_inc  = {1'b0, col_reg} + DimBits'(1);
    assign row_inc  = {1'b0, row_reg} + DimBits'(1);
    assign row_end  = col_inc >= cols_cl;
    assign last     = row_end && (row_inc >= rows_cl);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign depth    = s_tdata[DepthBits-1:0];
    assign depth_nz = depth != '0;

    // Counter update for the next pixel
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = last ? '0 : row_inc[RowBits-1:0];
            end else begin
                col_next = col_inc[ColBits-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Zero-depth pixels are dropped unless they close the frame
    assign push = accept && (depth_nz || last);

    always_comb begin
        push_item.depth       = depth;
        push_item.has_color   = s_tuser;
        push_item.blue        = s_tdata[23:16];
        push_item.green       = s_tdata[31:24];
        push_item.red         = s_tdata[39:32];
        push_item.col         = col_reg;
        push_item.row         = row_reg;
        push_item.point_valid = depth_nz;
        push_item.frame_end   = last;
    end

endmodule

>>> sv/dpc_queue.sv
// Short queue of classified items between the front end and the projection pipeline.
// Depends on dpc_pkg.
module dpc_queue
    import dpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  dpc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output dpc_item_t head_item
);

    dpc_item_t              mem_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QueueCntBits-1:0] cnt_reg, cnt_next;
    logic                    do_push, do_pop;

    assign full      = cnt_reg == QueueCntBits'(QueueDepth);
    assign not_empty = cnt_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem_reg[rd_reg];

    // Pointer and fill-count update
    always_comb begin
        wr_next  = do_push ? wr_reg + QueuePtrBits'(1) : wr_reg;
        rd_next  = do_pop  ? rd_reg + QueuePtrBits'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QueueCntBits'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QueueCntBits'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage write
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

>>> sv/dpc_back.sv
// Projection pipeline: offsets, two multiplies, rounding and saturation, output register.
// Depends on dpc_pkg.
module dpc_back
    import dpc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dpc_cam_t                cam,
    input  logic                    q_not_empty,
    input  dpc_item_t               q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataBits-1:0]  m_tdata,   // point_x, point_y, point_z, blue_out,
                                               // green_out, red_out, zero padding
    output logic [1:0]              m_tuser,   // color_present, point_valid
    output logic                    m_tlast
);

    localparam int MagBits  = CenterBits;
    localparam int ProdBits = MagBits + ZBits;
    localparam int FullBits = ProdBits + InvBits;
    localparam int QBits    = FullBits + 1 - 24;

    // Fields that ride alongside the arithmetic
    typedef struct packed {
        logic [ZBits-1:0]      z;
        logic [ColourBits-1:0] blue;
        logic [ColourBits-1:0] green;
        logic [ColourBits-1:0] red;
        logic                  color_present;
        logic                  point_valid;
        logic                  frame_end;
        logic                  x_neg;
        logic                  y_neg;
    } side_t;

    logic   advance;
    logic   v1_reg, v2_reg, v3_reg, vo_reg;
    side_t  s1_reg, s2_reg, s3_reg, s1_next;
    logic [MagBits-1:0]  xm_reg, ym_reg, xm_next, ym_next;
    logic [ProdBits-1:0] xt_reg, yt_reg;
    logic [FullBits-1:0] xp_reg, yp_reg;
    logic [CoordBits-1:0] x_out_reg, y_out_reg, x_next, y_next;
    side_t  so_reg;
    logic [CenterBits-1:0] pos_x, pos_y;
    logic [FullBits:0]     x_sum, y_sum;
    logic [QBits-1:0]      x_q, y_q;

    // Whole pipeline moves when the output register is free or being emptied
    assign advance = !vo_reg || m_tready;
    assign q_pop   = advance && q_not_empty;

    // Stage one: signed offset from the principal point as sign and magnitude
    always_comb begin
        pos_x = {q_item.col, 4'b0000};
        pos_y = {q_item.row, 4'b0000};
        s1_next.x_neg = pos_x < cam.center_x_q4;
        s1_next.y_neg = cam.center_y_q4 < pos_y;
        xm_next = s1_next.x_neg ? cam.center_x_q4 - pos_x : pos_x - cam.center_x_q4;
        ym_next = s1_next.y_neg ? pos_y - cam.center_y_q4 : cam.center_y_q4 - pos_y;
        // A frame-end marker without a point carries zero depth, giving zero coordinates
        s1_next.z             = q_item.point_valid ? q_item.depth : '0;
        s1_next.color_present = q_item.point_valid && q_item.has_color;
        s1_next.blue          = s1_next.color_present ? q_item.blue : '0;
        s1_next.green         = s1_next.color_present ? q_item.green : '0;
        s1_next.red           = s1_next.color_present ? q_item.red : '0;
        s1_next.point_valid   = q_item.point_valid;
        s1_next.frame_end     = q_item.frame_end;
    end

    // Stage four logic: round half up on magnitude, then saturate and apply the sign
    always_comb begin
        x_sum = {1'b0, xp_reg} + (FullBits+1)'(1 << 23);
        y_sum = {1'b0, yp_reg} + (FullBits+1)'(1 << 23);
        x_q   = x_sum[FullBits:24];
        y_q   = y_sum[FullBits:24];
        if (s3_reg.x_neg) begin
            x_next = (x_q > QBits'(4194304)) ? CoordBits'(4194304)
                                             : CoordBits'(~x_q + QBits'(1));
        end else begin
            x_next = (x_q > QBits'(4194303)) ? CoordBits'(4194303) : x_q[CoordBits-1:0];
        end
        if (s3_reg.y_neg) begin
            y_next = (y_q > QBits'(4194304)) ? CoordBits'(4194304)
                                             : CoordBits'(~y_q + QBits'(1));
        end else begin
            y_next = (y_q > QBits'(4194303)) ? CoordBits'(4194303) : y_q[CoordBits-1:0];
        end
    end

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // Stage payloads: magnitude times depth, then times the focal reciprocal
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_reg    <= s1_next;
            xm_reg    <= xm_next;
            ym_reg    <= ym_next;
            s2_reg    <= s1_reg;
            xt_reg    <= xm_reg * s1_reg.z;
            yt_reg    <= ym_reg * s1_reg.z;
            s3_reg    <= s2_reg;
            xp_reg    <= xt_reg * cam.inv_focal_x;
            yp_reg    <= yt_reg * cam.inv_focal_y;
            so_reg    <= s3_reg;
            x_out_reg <= x_next;
            y_out_reg <= y_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {2'b00, so_reg.red, so_reg.green, so_reg.blue, so_reg.z,
                       y_out_reg, x_out_reg};
    assign m_tuser  = {so_reg.point_valid, so_reg.color_present};
    assign m_tlast  = so_reg.frame_end;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for depth_to_point_cloud: directed table, then random frames.
// A predictor or table entry checks each point; depends on dpc_pkg and the RTL only.
module testbench;
    import dpc_pkg::*;

    localparam int FlushCycles   = 16;
    localparam int WatchdogLimit = 1000;
    localparam int RandomItems   = 950;
    localparam longint CoordMaxPos = 4194303;
    localparam longint CoordMinMag = 4194304;

    // One point as it leaves the block
    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic [ZBits-1:0]            z;
        logic [ColourBits-1:0]       blue;
        logic [ColourBits-1:0]       green;
        logic [ColourBits-1:0]       red;
        logic                        colour_present;
        logic                        point_valid;
        logic                        frame_end;
    } cloud_point_t;

    // One row of the directed table: a register write or a pixel
    typedef struct {
        bit                      is_write;
        logic [CfgIndexBits-1:0] reg_index;
        logic [CfgDataBits-1:0]  reg_value;
        logic [DepthBits-1:0]    depth;
        logic                    with_colour;
        logic [ColourBits-1:0]   blue;
        logic [ColourBits-1:0]   green;
        logic [ColourBits-1:0]   red;
        bit                      typed;
        cloud_point_t            want;
    } bench_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [InDataBits-1:0]   s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OutDataBits-1:0]  m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0]  cfg_data;

    // Camera settings and raster position as the predictor sees them
    logic [DimBits-1:0]    cam_cols = ColsReset;
    logic [DimBits-1:0]    cam_rows = RowsReset;
    logic [CenterBits-1:0] cam_cx   = CenterXReset;
    logic [CenterBits-1:0] cam_cy   = CenterYReset;
    logic [InvBits-1:0]    cam_ifx  = InvFxReset;
    logic [InvBits-1:0]    cam_ify  = InvFyReset;
    int unsigned           col_pos  = 0;
    int unsigned           row_pos  = 0;

    cloud_point_t expected_points[$];
    int           error_count  = 0;
    int           quiet_cycles = 0;
    bit           steady       = 1'b0;

    depth_to_point_cloud dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic note_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            note_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Rounded, saturated (pos - ctr) * depth * inv / 2^24 as a 23-bit code
    function automatic logic [CoordBits-1:0] project_axis(input int unsigned pos_q4,
            input int unsigned ctr_q4, input logic [DepthBits-1:0] depth,
            input logic [InvBits-1:0] inv);
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        neg = pos_q4 < ctr_q4;
        mag = neg ? ctr_q4 - pos_q4 : pos_q4 - ctr_q4;
        q = (mag * depth * inv + (64'd1 << 23)) >> 24;
        if (neg) begin
            if (q > CoordMinMag) q = CoordMinMag;
            q = -q;
        end else if (q > CoordMaxPos) begin
            q = CoordMaxPos;
        end
        return q[CoordBits-1:0];
    endfunction

    function automatic int unsigned clamp_dim(input logic [DimBits-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Advance the raster counters for one pixel; returns 1 when it yields an output item
    function automatic bit back_project_pixel(input logic [DepthBits-1:0] depth,
            input logic with_colour, input logic [ColourBits-1:0] blue,
            input logic [ColourBits-1:0] green, input logic [ColourBits-1:0] red,
            output cloud_point_t pt);
        int unsigned cols;
        int unsigned rows;
        int unsigned col;
        int unsigned row;
        bit          row_end;
        bit          frame_last;
        cols = clamp_dim(cam_cols, MaxCols);
        rows = clamp_dim(cam_rows, MaxRows);
        row_end = col_pos + 1 >= cols;
        frame_last = row_end && (row_pos + 1 >= rows);
        col = col_pos;
        row = row_pos;
        if (row_end) begin
            col_pos = 0;
            row_pos = frame_last ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        pt = '0;
        if (depth == 0 && !frame_last) return 1'b0;
        if (depth != 0) begin
            pt.x = project_axis(col << 4, cam_cx, depth, cam_ifx);
            pt.y = project_axis(cam_cy, row << 4, depth, cam_ify);
            pt.z = depth;
            if (with_colour) begin
                pt.blue = blue;
                pt.green = green;
                pt.red = red;
                pt.colour_present = 1'b1;
            end
            pt.point_valid = 1'b1;
        end
        pt.frame_end = frame_last;
        return 1'b1;
    endfunction

    function automatic cloud_point_t point_of(input int x, input int y, input int z,
            input int blue, input int green, input int red, input bit cp, input bit pv,
            input bit fe);
        cloud_point_t pt;
        pt.x = CoordBits'(x);
        pt.y = CoordBits'(y);
        pt.z = ZBits'(z);
        pt.blue = ColourBits'(blue);
        pt.green = ColourBits'(green);
        pt.red = ColourBits'(red);
        pt.colour_present = cp;
        pt.point_valid = pv;
        pt.frame_end = fe;
        return pt;
    endfunction

    function automatic bench_row_t pixel_row(input int depth, input bit with_colour,
            input int blue, input int green, input int red);
        bench_row_t row;
        row.is_write = 1'b0;
        row.reg_index = RegColsInUse;
        row.reg_value = '0;
        row.depth = DepthBits'(depth);
        row.with_colour = with_colour;
        row.blue = ColourBits'(blue);
        row.green = ColourBits'(green);
        row.red = ColourBits'(red);
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic bench_row_t checked_row(input int depth, input bit with_colour,
            input int blue, input int green, input int red, input cloud_point_t want);
        bench_row_t row;
        row = pixel_row(depth, with_colour, blue, green, red);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic bench_row_t reg_row(input logic [CfgIndexBits-1:0] idx, input int val);
        bench_row_t row;
        row = pixel_row(0, 1'b0, 0, 0, 0);
        row.is_write = 1'b1;
        row.reg_index = idx;
        row.reg_value = CfgDataBits'(val);
        return row;
    endfunction

    // Mostly no gap, some short ones and a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Small frames dominate so that frame ends come often; clamp cases now and then
    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 8);
        if (r < 70) return $urandom_range(9, 64);
        if (r < 78) return 0;
        if (r < 84) return MaxCols;
        if (r < 88) return $urandom_range(MaxCols + 1, 2047);
        return $urandom_range(1, 2047);
    endfunction

    function automatic int pick_center();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 16 * 9);
        if (r < 70) return 0;
        if (r < 80) return 16383;
        return $urandom_range(0, 16383);
    endfunction

    function automatic int pick_inv();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 1 << 16);
        if (r < 50) return 0;
        if (r < 60) return 24'hFFFFFF;
        return $urandom_range(0, 24'hFFFFFF);
    endfunction

    function automatic logic [DepthBits-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 20) return 16'hFFFF;
        if (r < 35) return DepthBits'($urandom_range(1, 255));
        return DepthBits'($urandom_range(0, 16'hFFFF));
    endfunction

    // Write one register; cfg_valid stays high for a following write
    task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
            input logic [CfgDataBits-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            RegColsInUse: cam_cols = val[DimBits-1:0];
            RegRowsInUse: cam_rows = val[DimBits-1:0];
            RegCenterXQ4: cam_cx = val[CenterBits-1:0];
            RegCenterYQ4: cam_cy = val[CenterBits-1:0];
            RegInvFocalX: cam_ifx = val[InvBits-1:0];
            RegInvFocalY: cam_ify = val[InvBits-1:0];
            default: ;
        endcase
    endtask

    // Offer one pixel after an optional gap and record what it should produce
    task automatic push_pixel(input logic [DepthBits-1:0] depth, input logic with_colour,
            input logic [ColourBits-1:0] blue, input logic [ColourBits-1:0] green,
            input logic [ColourBits-1:0] red, input bit typed, input cloud_point_t want);
        cloud_point_t predicted;
        bit           yields;
        int           gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {red, green, blue, depth};
        s_tuser <= with_colour;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        yields = back_project_pixel(depth, with_colour, blue, green, red, predicted);
        if (typed) begin
            expected_points = {expected_points, want};
        end else if (yields) begin
            expected_points = {expected_points, predicted};
        end
    endtask

    // Let every point drain and give items without a point time to leave the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (FlushCycles) @(posedge aclk);
    endtask

    // Main stimulus: reset, directed table, then random phases
    initial begin : stimulus
        bench_row_t dir_rows[$];
        bit         writing;
        int         sent;
        int         burst;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= RegColsInUse;
        cfg_data <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows = '{
            // Reset geometry: an empty pixel, then one point left of centre
            pixel_row(0, 1'b0, 8'h00, 8'h00, 8'h00),
            pixel_row(1000, 1'b1, 8'h12, 8'h34, 8'h56),
            // 2x2 frame entered with the column counter already past the row end
            reg_row(RegColsInUse, 2),
            reg_row(RegRowsInUse, 2),
            reg_row(RegInvFocalX, 0),
            reg_row(RegInvFocalY, 0),
            checked_row(5, 1'b1, 1, 2, 3, point_of(0, 0, 5, 1, 2, 3, 1, 1, 0)),
            pixel_row(0, 1'b1, 8'h09, 8'h09, 8'h09),
            // Frame end with no depth: an all-zero marker despite colour bytes
            checked_row(0, 1'b1, 8'hFF, 8'hFF, 8'hFF, point_of(0, 0, 0, 0, 0, 0, 0, 0, 1)),
            checked_row(16'hFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF,
                        point_of(0, 0, 65535, 255, 255, 255, 1, 1, 0)),
            // Colour bytes are dropped when the pixel carries no colour
            checked_row(1, 1'b0, 8'h77, 8'h88, 8'h99, point_of(0, 0, 1, 0, 0, 0, 0, 1, 0)),
            // Extreme centre and reciprocals drive both coordinates into saturation
            reg_row(RegCenterXQ4, 16383),
            reg_row(RegCenterYQ4, 16383),
            reg_row(RegInvFocalX, 24'hFFFFFF),
            reg_row(RegInvFocalY, 24'hFFFFFF),
            checked_row(16'hFFFF, 1'b1, 8'hAA, 8'h55, 8'h0F,
                        point_of(-4194304, 4194303, 65535, 8'hAA, 8'h55, 8'h0F, 1, 1, 0)),
            pixel_row(1, 1'b0, 8'h00, 8'h00, 8'h00),
            // Zero geometry clamps to a one-pixel frame
            reg_row(RegColsInUse, 0),
            reg_row(RegRowsInUse, 0),
            checked_row(0, 1'b0, 8'h00, 8'h00, 8'h00, point_of(0, 0, 0, 0, 0, 0, 0, 0, 1)),
            pixel_row(7, 1'b1, 8'h01, 8'h80, 8'hFE),
            // Oversized geometry clamps to the largest frame
            reg_row(RegColsInUse, 2047),
            reg_row(RegRowsInUse, 2047),
            pixel_row(16'h8000, 1'b1, 8'h5A, 8'hA5, 8'h3C),
            pixel_row(16'h00FF, 1'b0, 8'h00, 8'h00, 8'h00)
        };

        writing = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                if (!writing) settle();
                writing = 1'b1;
                write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
            end else begin
                if (writing) cfg_valid <= 1'b0;
                writing = 1'b0;
                push_pixel(dir_rows[i].depth, dir_rows[i].with_colour, dir_rows[i].blue,
                           dir_rows[i].green, dir_rows[i].red, dir_rows[i].typed,
                           dir_rows[i].want);
            end
        end

        // Random phases, each with fresh settings written while the block is idle
        sent = 0;
        while (sent < RandomItems) begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0)
                write_reg(RegColsInUse, CfgDataBits'(pick_dim()));
            if ($urandom_range(0, 2) != 0)
                write_reg(RegRowsInUse, CfgDataBits'(pick_dim()));
            if ($urandom_range(0, 2) != 0)
                write_reg(RegCenterXQ4, CfgDataBits'(pick_center()));
            if ($urandom_range(0, 2) != 0)
                write_reg(RegCenterYQ4, CfgDataBits'(pick_center()));
            if ($urandom_range(0, 2) != 0)
                write_reg(RegInvFocalX, CfgDataBits'(pick_inv()));
            if ($urandom_range(0, 2) != 0)
                write_reg(RegInvFocalY, CfgDataBits'(pick_inv()));
            cfg_valid <= 1'b0;
            burst = $urandom_range(50, 110);
            repeat (burst) begin
                push_pixel(pick_depth(), 1'($urandom_range(0, 1)),
                           ColourBits'($urandom_range(0, 255)),
                           ColourBits'($urandom_range(0, 255)),
                           ColourBits'($urandom_range(0, 255)), 1'b0, '0);
                sent++;
            end
        end

        settle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: ready in bursts, with stalls unless the phase runs steady
    initial begin : receiver
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = steady ? 0 : pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Compare each accepted point with the oldest expected one
    always @(posedge aclk) begin : point_check
        cloud_point_t got;
        cloud_point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            // m_tdata: x [22:0], y [45:23], z [61:46], blue, green, red from bit 62 up
            got.x = m_tdata[22:0];
            got.y = m_tdata[45:23];
            got.z = m_tdata[61:46];
            got.blue = m_tdata[69:62];
            got.green = m_tdata[77:70];
            got.red = m_tdata[85:78];
            got.colour_present = m_tuser[0];
            got.point_valid = m_tuser[1];
            got.frame_end = m_tlast;
            if (expected_points.size() == 0) begin
                note_error("point delivered with none expected");
            end else begin
                want = expected_points.pop_front();
                check_field("point_x", got.x, want.x);
                check_field("point_y", got.y, want.y);
                check_field("point_z", got.z, want.z);
                check_field("blue_out", got.blue, want.blue);
                check_field("green_out", got.green, want.green);
                check_field("red_out", got.red, want.red);
                check_field("color_present", got.colour_present, want.colour_present);
                check_field("point_valid", got.point_valid, want.point_valid);
                check_field("frame_end", got.frame_end, want.frame_end);
            end
        end
    end

    // Watchdog: ends the run when no handshake completes for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("TIMEOUT: no item accepted for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
